// File: design/w3sf_pkg.sv
// Shared types and constants for the weighted 3x3 smoothing filter.
// No dependencies; imported by w3sf_kernel, w3sf_out_buf and the top level.
package w3sf_pkg;

   localparam int CHAN_W     = 16;
   localparam int CSR_W      = 11;
   localparam int RESET_SIZE = 1024;

   // Result buffer depth; covers the read stage plus one stalled result.
   localparam int OBUF_DEPTH = 3;
   localparam int OBUF_PTR_W = 2;
   localparam int OBUF_CNT_W = 2;
   localparam int OCC_W      = 3;

   localparam logic [OBUF_PTR_W-1:0] OBUF_LAST_PTR = OBUF_PTR_W'(OBUF_DEPTH - 1);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pix_type;

   localparam int PIX_W = $bits(pix_type);

   // Neighbor pixels held in registers: (r,c+1), row r+1 and row r+2 windows.
   typedef struct packed {
      pix_type right;
      pix_type next0;
      pix_type next1;
      pix_type second0;
      pix_type second1;
   } win_type;

   // Which neighbor taps fall inside the image.
   typedef struct packed {
      logic col1;
      logic col2;
      logic row1;
      logic row2;
   } taps_type;

   typedef struct packed {
      pix_type pix;
      logic    last;
   } res_type;

endpackage

// File: design/w3sf_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Read-first on an address collision. No dependencies.
module w3sf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/w3sf_kernel.sv
// Shift-and-add 3x3 kernel for one pixel, all three channels.
// Depends on w3sf_pkg.
module w3sf_kernel (
   input  w3sf_pkg::pix_type  cur,
   input  w3sf_pkg::pix_type  below,
   input  w3sf_pkg::win_type  win,
   input  w3sf_pkg::taps_type taps,
   output w3sf_pkg::pix_type  result
);
   import w3sf_pkg::*;

   function automatic logic [CHAN_W-1:0] chan_sum(
      input logic [CHAN_W-1:0] c_cur,
      input logic [CHAN_W-1:0] c_right,
      input logic [CHAN_W-1:0] c_below,
      input logic [CHAN_W-1:0] c_n0,
      input logic [CHAN_W-1:0] c_n1,
      input logic [CHAN_W-1:0] c_s0,
      input logic [CHAN_W-1:0] c_s1,
      input taps_type          t
   );
      logic [CHAN_W-1:0] acc;
      acc = c_cur >> 1;
      if (t.col1)           acc = acc + (c_right >> 5);
      if (t.row1)           acc = acc + (c_below >> 5);
      if (t.row1 && t.col1) acc = acc + (c_n0 >> 2);
      if (t.row1 && t.col2) acc = acc + (c_n1 >> 5);
      if (t.row2 && t.col1) acc = acc + (c_s0 >> 5);
      if (t.row2 && t.col2) acc = acc + (c_s1 >> 3);
      return acc;
   endfunction

   assign result.red   = chan_sum(cur.red, win.right.red, below.red, win.next0.red,
                                  win.next1.red, win.second0.red, win.second1.red, taps);
   assign result.green = chan_sum(cur.green, win.right.green, below.green, win.next0.green,
                                  win.next1.green, win.second0.green, win.second1.green,
                                  taps);
   assign result.blue  = chan_sum(cur.blue, win.right.blue, below.blue, win.next0.blue,
                                  win.next1.blue, win.second0.blue, win.second1.blue, taps);

endmodule

// File: design/w3sf_out_buf.sv
// Small result queue in front of the response port.
// Depends on w3sf_pkg.
module w3sf_out_buf (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  w3sf_pkg::res_type                  push_data,
   output logic                               out_valid,
   input  logic                               out_ready,
   output w3sf_pkg::res_type                  out_data,
   output logic [w3sf_pkg::OBUF_CNT_W-1:0]    count
);
   import w3sf_pkg::*;

   res_type               entry_ff [OBUF_DEPTH];
   logic [OBUF_PTR_W-1:0] head_ff, head_in;
   logic [OBUF_PTR_W-1:0] tail_ff, tail_in;
   logic [OBUF_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  pop;

   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[head_ff];
   assign count     = cnt_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (pop) begin
         head_in = (head_ff == OBUF_LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == OBUF_LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

// File: design/weighted_3x3_smoothing_filter.sv
// Weighted 3x3 smoothing filter, top level. Uses w3sf_pkg, w3sf_ram, w3sf_kernel,
// w3sf_out_buf.
// Accepted requests pass the read stage, then w3sf_out_buf, before rsp_valid rises.
// Throughput: one pixel per clock while req_ready holds; one read/write pass per RAM.
// Reset: synchronous; size returns to 1024 (capped at MAX_SIZE), position to the
// start of an image, windows to zero. Line stores are not cleared.
module weighted_3x3_smoothing_filter #(
   parameter int MAX_SIZE = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [w3sf_pkg::CHAN_W-1:0]  req_red_in,
   input  logic [w3sf_pkg::CHAN_W-1:0]  req_green_in,
   input  logic [w3sf_pkg::CHAN_W-1:0]  req_blue_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [w3sf_pkg::CHAN_W-1:0]  rsp_red_out,
   output logic [w3sf_pkg::CHAN_W-1:0]  rsp_green_out,
   output logic [w3sf_pkg::CHAN_W-1:0]  rsp_blue_out,
   output logic                         rsp_last_of_image,
   input  logic                         csr_write_en,
   input  logic [w3sf_pkg::CSR_W-1:0]   csr_write_data
);
   import w3sf_pkg::*;

   localparam int ADDR_W = $clog2(MAX_SIZE);
   localparam int RESET_EFF = (RESET_SIZE > MAX_SIZE) ? MAX_SIZE : RESET_SIZE;
   localparam logic [ADDR_W-1:0] RESET_LAST = ADDR_W'(RESET_EFF - 1);
   localparam logic [ADDR_W-1:0] MAX_LAST   = ADDR_W'(MAX_SIZE - 1);

   // Position: last index of the image, current column and row (count down).
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ADDR_W-1:0] row_ff, row_in;

   logic              accept;
   logic [31:0]       size_wide;
   logic [ADDR_W-1:0] size_last;
   logic [ADDR_W-1:0] col_dist;
   logic [ADDR_W-1:0] row_dist;
   taps_type          taps;
   pix_type           req_pix;

   // Read stage: request whose line-store data arrives this cycle.
   logic              s1_valid_ff;
   pix_type           s1_pix_ff;
   logic [ADDR_W-1:0] s1_col_ff;
   taps_type          s1_taps_ff;
   logic              s1_last_ff;

   // Forwarding for a read of the entry written in the same cycle.
   logic              fwd_ff, fwd_in;
   pix_type           fwd_next_ff;
   pix_type           fwd_second_ff;

   win_type           win_ff, win_in;

   logic [PIX_W-1:0]  next_rdata;
   logic [PIX_W-1:0]  second_rdata;
   pix_type           below;
   pix_type           second;
   pix_type           filt;
   res_type           push_data;
   res_type           head;
   logic [OBUF_CNT_W-1:0] buf_count;

   assign req_pix = '{red: req_red_in, green: req_green_in, blue: req_blue_in};

   // Room for one more: buffered results plus the one in the read stage.
   assign req_ready = (OCC_W'(buf_count) + OCC_W'(s1_valid_ff)) < OCC_W'(OBUF_DEPTH);
   assign accept    = req_valid && req_ready;

   assign col_dist  = last_ff - col_ff;
   assign row_dist  = last_ff - row_ff;
   assign taps.col1 = (col_dist != '0);
   assign taps.col2 = (col_dist > ADDR_W'(1));
   assign taps.row1 = (row_dist != '0);
   assign taps.row2 = (row_dist > ADDR_W'(1));

   // Size zero acts as one; sizes above MAX_SIZE are capped.
   assign size_wide = 32'(csr_write_data);
   always_comb begin
      if (size_wide == 32'd0) begin
         size_last = '0;
      end else if (size_wide > 32'(MAX_SIZE)) begin
         size_last = MAX_LAST;
      end else begin
         size_last = ADDR_W'(size_wide - 32'd1);
      end
   end

   always_comb begin
      last_in = last_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (csr_write_en) begin
         last_in = size_last;
         col_in  = size_last;
         row_in  = size_last;
      end else if (accept) begin
         if (col_ff == '0) begin
            col_in = last_ff;
            row_in = (row_ff == '0) ? last_ff : row_ff - 1'b1;
         end else begin
            col_in = col_ff - 1'b1;
         end
      end
   end

   assign below  = fwd_ff ? fwd_next_ff : pix_type'(next_rdata);
   assign second = fwd_ff ? fwd_second_ff : pix_type'(second_rdata);

   assign fwd_in = accept && s1_valid_ff && (col_ff == s1_col_ff);

   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         win_in.right   = s1_pix_ff;
         win_in.next0   = below;
         win_in.next1   = win_ff.next0;
         win_in.second0 = second;
         win_in.second1 = win_ff.second0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff     <= RESET_LAST;
         col_ff      <= RESET_LAST;
         row_ff      <= RESET_LAST;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         win_ff      <= '0;
      end else begin
         last_ff     <= last_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         fwd_ff      <= fwd_in;
         win_ff      <= win_in;
      end
      if (accept) begin
         s1_pix_ff     <= req_pix;
         s1_col_ff     <= col_ff;
         s1_taps_ff    <= taps;
         s1_last_ff    <= (col_ff == '0) && (row_ff == '0);
         fwd_next_ff   <= s1_pix_ff;
         fwd_second_ff <= below;
      end
   end

   // Row r+1 store: written with the current pixel.
   w3sf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_SIZE)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (next_rdata)
   );

   // Row r+2 store: takes what row r+1 held at this column.
   w3sf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_SIZE)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (below),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (second_rdata)
   );

   w3sf_kernel u_kernel (
      .cur    (s1_pix_ff),
      .below  (below),
      .win    (win_ff),
      .taps   (s1_taps_ff),
      .result (filt)
   );

   assign push_data = '{pix: filt, last: s1_last_ff};

   w3sf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (push_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head),
      .count     (buf_count)
   );

   assign rsp_red_out       = head.pix.red;
   assign rsp_green_out     = head.pix.green;
   assign rsp_blue_out      = head.pix.blue;
   assign rsp_last_of_image = head.last;

endmodule
